// ===== src/motion_cycle_sequencer_macros.svh =====
// Assertion macros for the motion cycle sequencer checker.
// Expects clk and rst_n in the scope of the use site.
`ifndef MOTION_CYCLE_SEQUENCER_MACROS_SVH
`define MOTION_CYCLE_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mcs_pkg.sv =====
// Shared types and constants for the motion cycle sequencer.
// No dependencies; used by every module of the block.
`default_nettype none

package mcs_pkg;

    localparam int COUNT_BITS_DEF = 24;

    localparam int TARGET_W = 23;
    localparam int MS_W     = 16;
    localparam int CYC_W    = 8;
    localparam int MAG_W    = 16;
    localparam int CIDX_W   = 9;
    localparam int POS_W    = 24;
    localparam int PHASE_W  = 3;
    localparam int EV_W     = 3;
    localparam int ACT_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
    localparam logic [PHASE_W-1:0] PH_PRE  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_UP   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_HOLD = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DOWN = 3'd4;
    localparam logic [PHASE_W-1:0] PH_REST = 3'd5;
    localparam logic [PHASE_W-1:0] PH_POST = 3'd6;

    // action codes
    localparam logic [ACT_W-1:0] ACT_POLL  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_EDGE  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_START = 2'd3;

    // event codes
    localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EV_W-1:0] EV_STARTED = 3'd1;
    localparam logic [EV_W-1:0] EV_MAGNET  = 3'd2;
    localparam logic [EV_W-1:0] EV_ENCODER = 3'd3;
    localparam logic [EV_W-1:0] EV_DONE    = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UP_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_MS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLES    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_THR   = 2'd3;

    localparam logic [TARGET_W-1:0] UP_TARGET_RST = 23'd3000;
    localparam logic [MS_W-1:0]     PHASE_MS_RST  = 16'd5000;
    localparam logic [CYC_W-1:0]    CYCLES_RST    = 8'd3;
    localparam logic [MAG_W-1:0]    MAG_THR_RST   = 16'd0;

    localparam logic [MS_W-1:0]   TIMER_MAX = 16'hFFFF;
    localparam logic [CIDX_W-1:0] CYC_MAX   = 9'h1FF;

    typedef struct packed {
        logic [TARGET_W-1:0]    up_target;
        logic [MS_W-1:0]        phase_ms;
        logic [CYC_W-1:0]       cycles;
        logic signed [MAG_W-1:0] mag_stop_level;
    } cfg_t;

    // sequencer state, apart from the encoder count
    typedef struct packed {
        logic [PHASE_W-1:0]  phase;
        logic                active;
        logic [CIDX_W-1:0]   cycle_count;
        logic [MS_W-1:0]     phase_timer;
        logic [TARGET_W-1:0] move_target;
        logic                running;
        logic                dir_up;
    } seq_t;

    typedef struct packed {
        logic                motor_on;
        logic                motor_up;
        logic [PHASE_W-1:0]  phase;
        logic [CIDX_W-1:0]   cycle_index;
        logic [POS_W-1:0]    position;
        logic [EV_W-1:0]     event_code;
    } res_t;

endpackage

`default_nettype wire

// ===== src/mcs_cfg.sv =====
// Configuration register file of the motion cycle sequencer.
// Depends on mcs_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module mcs_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [mcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mcs_pkg::CFG_DATA_W-1:0]    cfg_data,
    output mcs_pkg::cfg_t                          cfg
);

    mcs_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.up_target      <= mcs_pkg::UP_TARGET_RST;
            cfg_reg.phase_ms       <= mcs_pkg::PHASE_MS_RST;
            cfg_reg.cycles         <= mcs_pkg::CYCLES_RST;
            cfg_reg.mag_stop_level <= mcs_pkg::MAG_THR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mcs_pkg::CFG_UP_TARGET: cfg_reg.up_target <= cfg_data[mcs_pkg::TARGET_W-1:0];
                mcs_pkg::CFG_PHASE_MS:  cfg_reg.phase_ms  <= cfg_data[mcs_pkg::MS_W-1:0];
                mcs_pkg::CFG_CYCLES:    cfg_reg.cycles    <= cfg_data[mcs_pkg::CYC_W-1:0];
                mcs_pkg::CFG_MAG_THR:
                    cfg_reg.mag_stop_level <= $signed(cfg_data[mcs_pkg::MAG_W-1:0]);
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== src/mcs_seq.sv =====
// Sequencer state and single-pass step logic for one beat.
// Depends on mcs_pkg for codes, cfg_t, seq_t and res_t.
`default_nettype none

module mcs_seq #(
    parameter int COUNT_BITS = mcs_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              advance,
    input  wire mcs_pkg::cfg_t                     cfg,
    input  wire logic [mcs_pkg::ACT_W-1:0]         action,
    input  wire logic signed [mcs_pkg::MAG_W-1:0]  mag_sample,
    output mcs_pkg::res_t                          res
);

    // wide enough for the signed count, the unsigned target and the position port
    localparam int CMP_W = ((COUNT_BITS > mcs_pkg::POS_W) ? COUNT_BITS : mcs_pkg::POS_W) + 1;
    localparam logic signed [COUNT_BITS-1:0] CMAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] CMIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    mcs_pkg::seq_t                st_reg;
    mcs_pkg::seq_t                st_next;
    logic signed [COUNT_BITS-1:0] enc_reg;
    logic signed [COUNT_BITS-1:0] enc_next;
    logic [mcs_pkg::EV_W-1:0]     ev;
    logic                         timed;
    logic                         magnet;
    logic signed [CMP_W-1:0]      enc_x;
    logic signed [CMP_W-1:0]      tgt_x;
    logic signed [CMP_W-1:0]      pos_x;

    always_comb
    begin
        st_next  = st_reg;
        enc_next = enc_reg;
        ev       = mcs_pkg::EV_NONE;

        // apply the action
        unique case (action)
            mcs_pkg::ACT_POLL: ;
            mcs_pkg::ACT_TICK:
            begin
                if (st_next.phase_timer != mcs_pkg::TIMER_MAX)
                    st_next.phase_timer = st_next.phase_timer + 16'd1;
            end
            mcs_pkg::ACT_EDGE:
            begin
                if (st_next.dir_up)
                begin
                    if (enc_next != CMAX)
                        enc_next = enc_next + COUNT_BITS'(1);
                end
                else if (enc_next != CMIN)
                    enc_next = enc_next - COUNT_BITS'(1);
            end
            mcs_pkg::ACT_START:
            begin
                if (!st_next.active)
                begin
                    st_next.active      = 1'b1;
                    st_next.cycle_count = '0;
                    st_next.phase       = mcs_pkg::PH_PRE;
                    st_next.phase_timer = '0;
                    ev                  = mcs_pkg::EV_STARTED;
                end
            end
            default: ;
        endcase

        // advance timed phases
        timed = st_next.phase_timer >= cfg.phase_ms;
        if (st_next.active && timed)
        begin
            unique case (st_next.phase)
                mcs_pkg::PH_PRE:
                begin
                    st_next.cycle_count = 9'd1;
                    st_next.dir_up      = 1'b1;
                    st_next.move_target = cfg.up_target;
                    st_next.running     = 1'b1;
                    st_next.phase       = mcs_pkg::PH_UP;
                end
                mcs_pkg::PH_HOLD:
                begin
                    st_next.dir_up      = 1'b0;
                    st_next.move_target = '0;
                    st_next.running     = 1'b1;
                    st_next.phase       = mcs_pkg::PH_DOWN;
                end
                mcs_pkg::PH_REST:
                begin
                    if (st_next.cycle_count != mcs_pkg::CYC_MAX)
                        st_next.cycle_count = st_next.cycle_count + 9'd1;
                    if (st_next.cycle_count <= {1'b0, cfg.cycles})
                    begin
                        st_next.dir_up      = 1'b1;
                        st_next.move_target = cfg.up_target;
                        st_next.running     = 1'b1;
                        st_next.phase       = mcs_pkg::PH_UP;
                    end
                    else
                    begin
                        st_next.phase       = mcs_pkg::PH_POST;
                        st_next.phase_timer = '0;
                    end
                end
                mcs_pkg::PH_POST:
                begin
                    st_next.active = 1'b0;
                    st_next.phase  = mcs_pkg::PH_IDLE;
                    ev             = mcs_pkg::EV_DONE;
                end
                default: ;
            endcase
        end

        // check the motor stop
        enc_x  = CMP_W'(enc_next);
        tgt_x  = CMP_W'($signed({1'b0, st_next.move_target}));
        magnet = mag_sample <= cfg.mag_stop_level;
        if (st_next.running)
        begin
            if (st_next.dir_up)
            begin
                if ((enc_x >= tgt_x) || magnet)
                begin
                    st_next.running     = 1'b0;
                    st_next.phase       = mcs_pkg::PH_HOLD;
                    st_next.phase_timer = '0;
                    ev = magnet ? mcs_pkg::EV_MAGNET : mcs_pkg::EV_ENCODER;
                end
            end
            else if (enc_x <= tgt_x)
            begin
                st_next.running     = 1'b0;
                enc_next            = '0;
                st_next.phase       = mcs_pkg::PH_REST;
                st_next.phase_timer = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase       <= mcs_pkg::PH_IDLE;
            st_reg.active      <= 1'b0;
            st_reg.cycle_count <= '0;
            st_reg.phase_timer <= '0;
            st_reg.move_target <= '0;
            st_reg.running     <= 1'b0;
            st_reg.dir_up      <= 1'b1;
            enc_reg            <= '0;
        end
        else if (advance)
        begin
            st_reg  <= st_next;
            enc_reg <= enc_next;
        end
    end

    assign pos_x = CMP_W'(enc_next);

    always_comb
    begin
        res.motor_on   = st_next.running;
        res.motor_up   = st_next.dir_up;
        res.phase      = st_next.phase;
        res.cycle_index = ((st_next.phase == mcs_pkg::PH_IDLE) ||
                           (st_next.phase == mcs_pkg::PH_PRE) ||
                           (st_next.phase == mcs_pkg::PH_POST)) ? '0 : st_next.cycle_count;
        res.position   = pos_x[mcs_pkg::POS_W-1:0];
        res.event_code = ev;
    end

endmodule

`default_nettype wire

// ===== src/motion_cycle_sequencer.sv =====
// Motion cycle sequencer: input register, step logic, result register.
// Depends on mcs_pkg, mcs_cfg and mcs_seq.
//
// Usage:
//   Input beats (action, mag_sample) enter on in_valid/in_ready; each beat
//   produces exactly one result beat (motor_on, motor_up, phase, cycle_index,
//   position, event_code) on out_valid/out_ready, in order.
//   Configuration is written through cfg_we/cfg_index/cfg_data, one register
//   per cycle, by a user who must do so only while no beat is in flight;
//   the block does not enforce this.
//   Path: an accepted beat is held in the input register, runs through the
//   step logic and lands in the result register, which raises out_valid.
//   Throughput: one beat per cycle unless out_ready stalls, set by the
//   single-pass step logic updating the sequencer state between the registers.
//   Stall: when out_ready is low the result holds, the input register keeps
//   one more beat, and in_ready drops once both are full.
//   Reset: rst_n empties both registers, the sequencer returns to idle with
//   zero count and upward direction, and configuration returns to its
//   defaults (target 3000, 5000 ms, cycle setting 3, threshold 0).
`default_nettype none

module motion_cycle_sequencer #(
    parameter int COUNT_BITS = mcs_pkg::COUNT_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [mcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [mcs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [mcs_pkg::ACT_W-1:0]          action,
    input  wire logic signed [mcs_pkg::MAG_W-1:0]   mag_sample,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    motor_on,
    output logic                                    motor_up,
    output logic [mcs_pkg::PHASE_W-1:0]             phase,
    output logic [mcs_pkg::CIDX_W-1:0]              cycle_index,
    output logic signed [mcs_pkg::POS_W-1:0]        position,
    output logic [mcs_pkg::EV_W-1:0]                event_code
);

    mcs_pkg::cfg_t                  cfg;
    mcs_pkg::res_t                  res;
    mcs_pkg::res_t                  res_reg;
    logic                           in_full_reg;
    logic                           out_valid_reg;
    logic [mcs_pkg::ACT_W-1:0]      action_reg;
    logic signed [mcs_pkg::MAG_W-1:0] mag_reg;
    logic                           advance;

    // move the held beat forward when the result register is free or draining
    assign advance  = in_full_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_full_reg || advance;

    mcs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mcs_seq #(
        .COUNT_BITS (COUNT_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .cfg        (cfg),
        .action     (action_reg),
        .mag_sample (mag_reg),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                in_full_reg <= 1'b1;
            else if (advance)
                in_full_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg <= action;
            mag_reg    <= mag_sample;
        end
        if (advance)
            res_reg <= res;
    end

    assign out_valid   = out_valid_reg;
    assign motor_on    = res_reg.motor_on;
    assign motor_up    = res_reg.motor_up;
    assign phase       = res_reg.phase;
    assign cycle_index = res_reg.cycle_index;
    assign position    = $signed(res_reg.position);
    assign event_code  = res_reg.event_code;

endmodule

`default_nettype wire

// ===== src/mcs_checker.sv =====
// Port-level checker for the motion cycle sequencer, bound to the top level.
// Depends on mcs_pkg and motion_cycle_sequencer_macros.svh.
`default_nettype none

`include "motion_cycle_sequencer_macros.svh"

module mcs_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               out_valid,
    input wire logic                               out_ready,
    input wire logic                               motor_on,
    input wire logic                               motor_up,
    input wire logic [mcs_pkg::PHASE_W-1:0]        phase,
    input wire logic [mcs_pkg::CIDX_W-1:0]         cycle_index,
    input wire logic signed [mcs_pkg::POS_W-1:0]   position,
    input wire logic [mcs_pkg::EV_W-1:0]           event_code
);

    // a stalled result beat holds
    `MCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(position) && $stable(phase) && $stable(event_code), "result beat changed while stalled")

    // the cycle number reads zero outside the move loop
    `MCS_ASSERT_NOW(a_cycle_zero, out_valid && ((phase == mcs_pkg::PH_IDLE) || (phase == mcs_pkg::PH_PRE) || (phase == mcs_pkg::PH_POST)), cycle_index == '0, "cycle index nonzero outside loop")

    // drive is on only during a move
    `MCS_ASSERT_NOW(a_drive_phase, out_valid && motor_on, (phase == mcs_pkg::PH_UP) || (phase == mcs_pkg::PH_DOWN), "motor on outside a move phase")

    // an up-move stop lands in hold with the drive off
    `MCS_ASSERT_NOW(a_stop_hold, out_valid && ((event_code == mcs_pkg::EV_MAGNET) || (event_code == mcs_pkg::EV_ENCODER)), (phase == mcs_pkg::PH_HOLD) && !motor_on && motor_up, "stop event without hold")

    // session end returns to idle
    `MCS_ASSERT_NOW(a_done_idle, out_valid && (event_code == mcs_pkg::EV_DONE), (phase == mcs_pkg::PH_IDLE) && !motor_on, "session done outside idle")

endmodule

bind motion_cycle_sequencer mcs_checker u_mcs_checker (.*);

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking bench for motion_cycle_sequencer: directed table, then random sessions.
// Depends on mcs_pkg and the RTL of the block; checks every result beat against the
// directed table's expected value or a cycle-free model of the sequencer kept in step with the accepted input beats.
`timescale 1ns / 1ps

module testbench;

    import mcs_pkg::*;

    localparam int CNT_MAX       = (1 << (COUNT_BITS_DEF - 1)) - 1;
    localparam int CNT_MIN       = -CNT_MAX - 1;
    localparam int SETTLE_CYCLES = 4;

    typedef struct {
        logic                    is_wr;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        logic [ACT_W-1:0]        act;
        logic signed [MAG_W-1:0] mag;
        logic                    typed;
        res_t                    res;
    } opening_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [ACT_W-1:0]        action;
    logic signed [MAG_W-1:0] mag_sample;
    logic                    out_valid;
    logic                    out_ready;
    logic                    motor_on;
    logic                    motor_up;
    logic [PHASE_W-1:0]      phase;
    logic [CIDX_W-1:0]       cycle_index;
    logic signed [POS_W-1:0] position;
    logic [EV_W-1:0]         event_code;

    // model of the sequencer
    cfg_t cfg;
    seq_t seq;
    int   seq_pos;

    res_t         status_due [$];
    res_t         want;
    res_t         got;
    opening_row_t opening [$];
    int unsigned  faults         = 0;
    int unsigned  beats_sent     = 0;
    int unsigned  src_gap_pct    = 11;
    int unsigned  sink_stall_pct = 60;

    motion_cycle_sequencer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .mag_sample  (mag_sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .motor_on    (motor_on),
        .motor_up    (motor_up),
        .phase       (phase),
        .cycle_index (cycle_index),
        .position    (position),
        .event_code  (event_code)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply the action, then advance the timed phases, then check the motor stop.
    function automatic res_t advance_sequencer(logic [ACT_W-1:0] act,
                                               logic signed [MAG_W-1:0] mag);
        res_t            r;
        logic [EV_W-1:0] ev;
        logic            timed;
        logic            magnet;
        ev = EV_NONE;
        case (act)
            ACT_TICK:
                if (seq.phase_timer != TIMER_MAX)
                    seq.phase_timer = seq.phase_timer + 1'b1;
            ACT_EDGE:
                if (seq.dir_up)
                begin
                    if (seq_pos < CNT_MAX)
                        seq_pos = seq_pos + 1;
                end
                else if (seq_pos > CNT_MIN)
                    seq_pos = seq_pos - 1;
            ACT_START:
                if (!seq.active)
                begin
                    seq.active      = 1'b1;
                    seq.cycle_count = '0;
                    seq.phase       = PH_PRE;
                    seq.phase_timer = '0;
                    ev              = EV_STARTED;
                end
            default: ;
        endcase

        if (seq.active)
        begin
            timed = (seq.phase_timer >= cfg.phase_ms);
            case (seq.phase)
                PH_PRE:
                    if (timed)
                    begin
                        seq.cycle_count = 9'd1;
                        seq.dir_up      = 1'b1;
                        seq.move_target = cfg.up_target;
                        seq.running     = 1'b1;
                        seq.phase       = PH_UP;
                    end
                PH_HOLD:
                    if (timed)
                    begin
                        seq.dir_up      = 1'b0;
                        seq.move_target = '0;
                        seq.running     = 1'b1;
                        seq.phase       = PH_DOWN;
                    end
                PH_REST:
                    if (timed)
                    begin
                        if (seq.cycle_count != CYC_MAX)
                            seq.cycle_count = seq.cycle_count + 1'b1;
                        if (seq.cycle_count <= {1'b0, cfg.cycles})
                        begin
                            seq.dir_up      = 1'b1;
                            seq.move_target = cfg.up_target;
                            seq.running     = 1'b1;
                            seq.phase       = PH_UP;
                        end
                        else
                        begin
                            seq.phase       = PH_POST;
                            seq.phase_timer = '0;
                        end
                    end
                PH_POST:
                    if (timed)
                    begin
                        seq.active = 1'b0;
                        seq.phase  = PH_IDLE;
                        ev         = EV_DONE;
                    end
                default: ;
            endcase
        end

        if (seq.running)
        begin
            magnet = (mag <= $signed(cfg.mag_stop_level));
            if (seq.dir_up)
            begin
                if (seq_pos >= int'({1'b0, seq.move_target}) || magnet)
                begin
                    seq.running     = 1'b0;
                    seq.phase       = PH_HOLD;
                    seq.phase_timer = '0;
                    ev              = magnet ? EV_MAGNET : EV_ENCODER;
                end
            end
            else if (seq_pos <= int'({1'b0, seq.move_target}))
            begin
                seq.running     = 1'b0;
                seq_pos         = 0;
                seq.phase       = PH_REST;
                seq.phase_timer = '0;
            end
        end

        r.motor_on    = seq.running;
        r.motor_up    = seq.dir_up;
        r.phase       = seq.phase;
        r.cycle_index = (seq.phase == PH_IDLE || seq.phase == PH_PRE || seq.phase == PH_POST)
                        ? '0 : seq.cycle_count;
        r.position    = seq_pos[POS_W-1:0];
        r.event_code  = ev;
        return r;
    endfunction

    function automatic res_t status(logic on, logic up, logic [PHASE_W-1:0] ph,
                                    int cidx, int pos, logic [EV_W-1:0] ev);
        res_t r;
        r.motor_on    = on;
        r.motor_up    = up;
        r.phase       = ph;
        r.cycle_index = cidx[CIDX_W-1:0];
        r.position    = pos[POS_W-1:0];
        r.event_code  = ev;
        return r;
    endfunction

    function automatic opening_row_t beat_is(logic [ACT_W-1:0] act,
                                             logic signed [MAG_W-1:0] mag, res_t res);
        opening_row_t row;
        row.is_wr = 1'b0;
        row.idx   = '0;
        row.data  = '0;
        row.act   = act;
        row.mag   = mag;
        row.typed = 1'b1;
        row.res   = res;
        return row;
    endfunction

    function automatic opening_row_t beat(logic [ACT_W-1:0] act, logic signed [MAG_W-1:0] mag);
        opening_row_t row;
        row       = beat_is(act, mag, '0);
        row.typed = 1'b0;
        return row;
    endfunction

    function automatic opening_row_t reg_wr(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] data);
        opening_row_t row;
        row       = beat(ACT_POLL, '0);
        row.is_wr = 1'b1;
        row.idx   = idx;
        row.data  = data;
        return row;
    endfunction

    function automatic logic signed [MAG_W-1:0] mag_above(logic signed [MAG_W-1:0] thr);
        int lo;
        lo = int'(thr) + 1;
        if (lo > 32767)
            return thr;
        return 16'(lo + int'($urandom_range(32767 - lo)));
    endfunction

    function automatic logic signed [MAG_W-1:0] mag_at_or_below(logic signed [MAG_W-1:0] thr);
        return 16'(-32768 + int'($urandom_range(int'(thr) + 32768)));
    endfunction

    task automatic send_beat(input logic [ACT_W-1:0] act, input logic signed [MAG_W-1:0] mag,
                             input logic typed = 1'b0, input res_t typed_res = '0);
        res_t predicted;
        // keep valid high across back-to-back beats; drop it only for a gap
        if ($urandom_range(99) < src_gap_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_gap_pct);
        end
        in_valid   <= 1'b1;
        action     <= act;
        mag_sample <= mag;
        do @(posedge clk); while (!in_ready);
        predicted = advance_sequencer(act, mag);
        status_due.push_back(typed ? typed_res : predicted);
        beats_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_UP_TARGET: cfg.up_target      = data[TARGET_W-1:0];
            CFG_PHASE_MS:  cfg.phase_ms       = data[MS_W-1:0];
            CFG_CYCLES:    cfg.cycles         = data[CYC_W-1:0];
            CFG_MAG_THR:   cfg.mag_stop_level = data[MAG_W-1:0];
            default: ;
        endcase
    endtask

    // One session with random content, steered by the model's phase; a few noise beats.
    task automatic run_session();
        int unsigned roll;
        int unsigned n;
        n = 0;
        repeat ($urandom_range(3))
            send_beat(2'($urandom), 16'($urandom));
        send_beat(ACT_START, mag_above(cfg.mag_stop_level));
        while (seq.active && n < 4000)
        begin
            roll = $urandom_range(99);
            n++;
            if (roll < 8)
                send_beat(2'($urandom), 16'($urandom));
            else
                case (seq.phase)
                    PH_UP:
                        send_beat(roll < 16 ? ACT_TICK : ACT_EDGE,
                                  roll < 20 ? mag_at_or_below(cfg.mag_stop_level)
                                            : mag_above(cfg.mag_stop_level));
                    PH_DOWN:
                        send_beat(roll < 16 ? ACT_POLL : ACT_EDGE,
                                  mag_above(cfg.mag_stop_level));
                    default:
                        send_beat(roll < 14 ? ACT_POLL : (roll < 18 ? ACT_START : ACT_TICK),
                                  mag_above(cfg.mag_stop_level));
                endcase
        end
    endtask

    task automatic check_field(string name, logic signed [31:0] exp_v, logic signed [31:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            faults++;
        end
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            got.motor_on    = motor_on;
            got.motor_up    = motor_up;
            got.phase       = phase;
            got.cycle_index = cycle_index;
            got.position    = position;
            got.event_code  = event_code;
            if (status_due.size() == 0)
            begin
                $error("result beat with nothing expected");
                faults++;
            end
            else
            begin
                want = status_due.pop_front();
                check_field("motor_on", want.motor_on, got.motor_on);
                check_field("motor_up", want.motor_up, got.motor_up);
                check_field("phase", want.phase, got.phase);
                check_field("cycle_index", want.cycle_index, got.cycle_index);
                check_field("position", $signed(want.position), $signed(got.position));
                check_field("event_code", want.event_code, got.event_code);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic signed [MAG_W-1:0] thr;
        int unsigned             goal;

        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        action     <= ACT_POLL;
        mag_sample <= '0;
        out_ready  <= 1'b0;

        cfg.up_target      = UP_TARGET_RST;
        cfg.phase_ms       = PHASE_MS_RST;
        cfg.cycles         = CYCLES_RST;
        cfg.mag_stop_level = MAG_THR_RST;
        seq                = '0;
        seq.phase          = PH_IDLE;
        seq.dir_up         = 1'b1;
        seq_pos            = 0;

        // reset defaults, a zero-length session with the magnet and the target both hit,
        // then the register extremes
        opening.push_back(beat_is(ACT_POLL, 16'sd0, status(1'b0, 1'b1, PH_IDLE, 0, 0, EV_NONE)));
        opening.push_back(beat_is(ACT_EDGE, 16'sh7FFF,
                                  status(1'b0, 1'b1, PH_IDLE, 0, 1, EV_NONE)));
        opening.push_back(reg_wr(CFG_CYCLES, 23'd0));
        opening.push_back(reg_wr(CFG_PHASE_MS, 23'd0));
        opening.push_back(reg_wr(CFG_UP_TARGET, 23'd0));
        opening.push_back(beat_is(ACT_START, 16'sh8000,
                                  status(1'b0, 1'b1, PH_HOLD, 1, 1, EV_MAGNET)));
        opening.push_back(beat_is(ACT_START, 16'sd5,
                                  status(1'b1, 1'b0, PH_DOWN, 1, 1, EV_NONE)));
        opening.push_back(beat_is(ACT_EDGE, 16'sd5, status(1'b0, 1'b0, PH_REST, 1, 0, EV_NONE)));
        opening.push_back(beat_is(ACT_POLL, 16'sd5, status(1'b0, 1'b0, PH_POST, 0, 0, EV_NONE)));
        opening.push_back(beat_is(ACT_POLL, 16'sd5, status(1'b0, 1'b0, PH_IDLE, 0, 0, EV_DONE)));
        opening.push_back(beat_is(ACT_EDGE, 16'sd5, status(1'b0, 1'b0, PH_IDLE, 0, -1, EV_NONE)));
        opening.push_back(reg_wr(CFG_UP_TARGET, 23'h7FFFFF));
        opening.push_back(reg_wr(CFG_PHASE_MS, 23'hFFFF));
        opening.push_back(reg_wr(CFG_CYCLES, 23'hFF));
        opening.push_back(reg_wr(CFG_MAG_THR, 23'h7FFF));
        opening.push_back(beat_is(ACT_START, 16'sh7FFF,
                                  status(1'b0, 1'b0, PH_PRE, 0, -1, EV_STARTED)));
        opening.push_back(beat(ACT_TICK, 16'sd0));
        opening.push_back(reg_wr(CFG_PHASE_MS, 23'd1));
        opening.push_back(beat_is(ACT_POLL, -16'sd1,
                                  status(1'b0, 1'b1, PH_HOLD, 1, -1, EV_MAGNET)));
        opening.push_back(reg_wr(CFG_MAG_THR, 23'h8000));
        opening.push_back(beat_is(ACT_TICK, 16'sd0, status(1'b0, 1'b0, PH_REST, 1, 0, EV_NONE)));
        opening.push_back(beat_is(ACT_TICK, 16'sh8001, status(1'b1, 1'b1, PH_UP, 2, 0, EV_NONE)));
        opening.push_back(beat(ACT_EDGE, 16'sh7FFF));
        opening.push_back(beat(ACT_EDGE, 16'sh8000));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
        begin
            if (opening[i].is_wr)
                write_reg(opening[i].idx, opening[i].data);
            else
                send_beat(opening[i].act, opening[i].mag, opening[i].typed, opening[i].res);
        end

        for (int stage = 0; stage < 3; stage++)
        begin
            case (stage)
                0:
                begin
                    src_gap_pct    = 11;
                    sink_stall_pct = 60;
                end
                1:
                begin
                    src_gap_pct    = 60;
                    sink_stall_pct = 11;
                end
                default:
                begin
                    src_gap_pct    = 0;
                    sink_stall_pct = 0;
                end
            endcase
            goal = beats_sent + 630;
            while (beats_sent < goal)
            begin
                write_reg(CFG_UP_TARGET, ($urandom_range(19) == 0) ? 23'($urandom_range(60))
                                                                     : 23'($urandom_range(12)));
                write_reg(CFG_PHASE_MS, ($urandom_range(11) == 0) ? 23'd0
                                                                    : 23'($urandom_range(6, 1)));
                write_reg(CFG_CYCLES, ($urandom_range(11) == 0) ? 23'd0
                                                                  : 23'($urandom_range(3, 1)));
                thr = ($urandom_range(4) == 0) ? 16'($urandom)
                                               : 16'(int'($urandom_range(400)) - 200);
                write_reg(CFG_MAG_THR, {7'd0, thr});
                run_session();
            end
        end

        settle();
        if (faults == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
